FILE: hw/rtl/tlsplit_pkg.sv
// ----------------------------------------------------------------------------
// tlsplit_pkg
// Shared types and constants for the text line splitter with tab expansion.
// ----------------------------------------------------------------------------
package tlsplit_pkg;

  // Field widths
  localparam int unsigned CharW     = 8;
  localparam int unsigned LineLenW  = 10;
  localparam int unsigned MaxLineW  = 11;
  localparam int unsigned TabW      = 6;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = MaxLineW;
  localparam int unsigned DivCntW   = $clog2(LineLenW + 1);

  // Register reset values
  localparam logic [MaxLineW-1:0] MaxLineRst = MaxLineW'(512);
  localparam logic [TabW-1:0]     TabRst     = TabW'(8);

  // Character codes
  localparam logic [CharW-1:0] CharNul   = 8'd0;
  localparam logic [CharW-1:0] CharTab   = 8'd9;
  localparam logic [CharW-1:0] CharLf    = 8'd10;
  localparam logic [CharW-1:0] CharCr    = 8'd13;
  localparam logic [CharW-1:0] CharCtrlZ = 8'd26;
  localparam logic [CharW-1:0] CharSpace = 8'd32;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_LINE     = 2'd0,
    CFG_TAB_WIDTH    = 2'd1,
    CFG_KEEP_TABS    = 2'd2,
    CFG_IGNORE_CTRLZ = 2'd3
  } cfg_idx_e;

  // Kind of result pushed into the output register
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_CHAR,
    EMIT_SPACE,
    EMIT_EOL,
    EMIT_STATUS
  } emit_e;

  typedef struct packed {
    logic [CharW-1:0] byte_value;
    logic             last_byte;
  } in_t;

  typedef struct packed {
    logic [CharW-1:0]    out_char;
    logic                char_valid;
    logic                end_of_line;
    logic [LineLenW-1:0] line_length;
    logic                crlf_seen;
    logic                input_stopped;
    logic                last_of_run;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic  load_byte;
    logic  set_crlf;
    logic  set_stop;
    logic  div_start;
    logic  load_cnt;
    emit_e emit;
    logic  emit_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic stopped;
    logic line_open;
    logic last_byte;
    logic is_cr;
    logic is_ctrlz;
    logic is_eol_char;
    logic is_tab;
    logic char_wrap;
    logic div_done;
    logic tab_wrap;
    logic cnt_one;
    logic out_free;
  } stat_t;

endpackage

FILE: hw/rtl/tlsplit_dp.sv
// ----------------------------------------------------------------------------
// tlsplit_dp
// Datapath: config registers, line state, remainder unit, space counter and
// output register.
// ----------------------------------------------------------------------------
module tlsplit_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [tlsplit_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tlsplit_pkg::CfgDataW-1:0]  cfg_data_i,
  input  tlsplit_pkg::in_t                  in_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output tlsplit_pkg::out_t                 out_data_o,
  input  tlsplit_pkg::cmd_t                 cmd_i,
  output tlsplit_pkg::stat_t                stat_o
);

  localparam int unsigned LenW = tlsplit_pkg::LineLenW;
  localparam int unsigned TwW  = tlsplit_pkg::TabW;

  // Config registers
  logic [tlsplit_pkg::MaxLineW-1:0] max_line_q;
  logic [TwW-1:0]                   tab_width_q;
  logic                             keep_tabs_q;
  logic                             ignore_ctrlz_q;

  // Line state
  logic [LenW-1:0] line_len_q, line_len_d;
  logic            line_open_q, line_open_d;
  logic            crlf_q, stop_q;
  tlsplit_pkg::in_t byte_q;

  // Remainder unit and space counter
  logic [TwW-1:0]                    div_rem_q;
  logic [LenW-1:0]                   div_sh_q;
  logic [tlsplit_pkg::DivCntW-1:0]   div_cnt_q;
  logic [TwW-1:0]                    spc_cnt_q;

  // Output register
  logic              out_valid_q;
  tlsplit_pkg::out_t out_q, out_d;

  logic [LenW-1:0] limit;
  logic [TwW-1:0]  tw_sat, tw;
  logic [TwW:0]    r_shift, r_sub;
  logic            r_ge;
  logic [TwW-1:0]  tb;
  logic [LenW:0]   tab_sum;
  logic            out_free;

  // Saturate the registers into usable limits
  always_comb begin
    if (max_line_q < tlsplit_pkg::MaxLineW'(3)) begin
      limit = LenW'(2);
    end else if (max_line_q > tlsplit_pkg::MaxLineW'(1024)) begin
      limit = LenW'(1023);
    end else begin
      limit = LenW'(max_line_q - tlsplit_pkg::MaxLineW'(1));
    end
    if (tab_width_q == '0) begin
      tw_sat = TwW'(1);
    end else if (tab_width_q > TwW'(62)) begin
      tw_sat = TwW'(62);
    end else begin
      tw_sat = tab_width_q;
    end
    if ({{(LenW-TwW){1'b0}}, tw_sat} > limit - LenW'(1)) begin
      tw = TwW'(limit - LenW'(1));
    end else begin
      tw = tw_sat;
    end
  end

  // One restoring step per cycle
  assign r_shift = {div_rem_q, div_sh_q[LenW-1]};
  assign r_sub   = r_shift - {1'b0, tw};
  assign r_ge    = (r_shift >= {1'b0, tw});

  assign tb      = tw - div_rem_q;
  assign tab_sum = {1'b0, line_len_q} + {{(LenW+1-TwW){1'b0}}, tb};

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o             = '0;
    stat_o.stopped     = stop_q;
    stat_o.line_open   = line_open_q;
    stat_o.last_byte   = byte_q.last_byte;
    stat_o.is_cr       = (byte_q.byte_value == tlsplit_pkg::CharCr);
    stat_o.is_ctrlz    = (byte_q.byte_value == tlsplit_pkg::CharCtrlZ) && !ignore_ctrlz_q;
    stat_o.is_eol_char = (byte_q.byte_value == tlsplit_pkg::CharLf) ||
                         (byte_q.byte_value == tlsplit_pkg::CharNul);
    stat_o.is_tab      = (byte_q.byte_value == tlsplit_pkg::CharTab) && !keep_tabs_q;
    stat_o.char_wrap   = (line_len_q >= limit);
    stat_o.div_done    = (div_cnt_q == '0);
    stat_o.tab_wrap    = (tab_sum >= {1'b0, limit});
    stat_o.cnt_one     = (spc_cnt_q == TwW'(1));
    stat_o.out_free    = out_free;
  end

  // Build the next result
  always_comb begin
    out_d               = '0;
    out_d.crlf_seen     = crlf_q;
    out_d.input_stopped = stop_q;
    out_d.last_of_run   = cmd_i.emit_last;
    case (cmd_i.emit)
      tlsplit_pkg::EMIT_CHAR: begin
        out_d.out_char   = byte_q.byte_value;
        out_d.char_valid = 1'b1;
      end
      tlsplit_pkg::EMIT_SPACE: begin
        out_d.out_char   = tlsplit_pkg::CharSpace;
        out_d.char_valid = 1'b1;
      end
      tlsplit_pkg::EMIT_EOL: begin
        out_d.end_of_line = 1'b1;
        out_d.line_length = line_len_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    line_len_d  = line_len_q;
    line_open_d = line_open_q;
    if (cmd_i.set_crlf) begin
      line_open_d = 1'b1;
    end
    case (cmd_i.emit)
      tlsplit_pkg::EMIT_CHAR, tlsplit_pkg::EMIT_SPACE: begin
        line_len_d  = line_len_q + LenW'(1);
        line_open_d = 1'b1;
      end
      tlsplit_pkg::EMIT_EOL: begin
        line_len_d  = '0;
        line_open_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q     <= tlsplit_pkg::MaxLineRst;
      tab_width_q    <= tlsplit_pkg::TabRst;
      keep_tabs_q    <= 1'b0;
      ignore_ctrlz_q <= 1'b0;
      line_len_q     <= '0;
      line_open_q    <= 1'b0;
      crlf_q         <= 1'b0;
      stop_q         <= 1'b0;
      div_cnt_q      <= '0;
      spc_cnt_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (tlsplit_pkg::cfg_idx_e'(cfg_index_i))
          tlsplit_pkg::CFG_MAX_LINE:     max_line_q     <= cfg_data_i;
          tlsplit_pkg::CFG_TAB_WIDTH:    tab_width_q    <= cfg_data_i[TwW-1:0];
          tlsplit_pkg::CFG_KEEP_TABS:    keep_tabs_q    <= cfg_data_i[0];
          tlsplit_pkg::CFG_IGNORE_CTRLZ: ignore_ctrlz_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      line_len_q  <= line_len_d;
      line_open_q <= line_open_d;
      if (cmd_i.set_crlf) begin
        crlf_q <= 1'b1;
      end
      if (cmd_i.set_stop) begin
        stop_q <= 1'b1;
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= tlsplit_pkg::DivCntW'(LenW);
      end else if (div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - tlsplit_pkg::DivCntW'(1);
      end
      if (cmd_i.load_cnt) begin
        spc_cnt_q <= stat_o.tab_wrap ? tw : tb;
      end else if (cmd_i.emit == tlsplit_pkg::EMIT_SPACE) begin
        spc_cnt_q <= spc_cnt_q - TwW'(1);
      end
      if (cmd_i.emit != tlsplit_pkg::EMIT_NONE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      byte_q <= in_data_i;
    end
    if (cmd_i.div_start) begin
      div_rem_q <= '0;
      div_sh_q  <= line_len_q;
    end else if (div_cnt_q != '0) begin
      div_rem_q <= r_ge ? r_sub[TwW-1:0] : r_shift[TwW-1:0];
      div_sh_q  <= {div_sh_q[LenW-2:0], 1'b0};
    end
    if (cmd_i.emit != tlsplit_pkg::EMIT_NONE) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/tlsplit_ctrl.sv
// ----------------------------------------------------------------------------
// tlsplit_ctrl
// Controller: sequences bytes through classify, tab remainder and emission.
// ----------------------------------------------------------------------------
module tlsplit_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tlsplit_pkg::stat_t stat_i,
  output tlsplit_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_CHAR,
    S_WRAP_CHAR,
    S_DIV,
    S_TAB_CHK,
    S_WRAP_TAB,
    S_SPACES,
    S_EOL_END,
    S_STATUS
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.emit = tlsplit_pkg::EMIT_NONE;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        // drop bytes once input has stopped
        if (in_valid_i && !stat_i.stopped) begin
          cmd_o.load_byte = 1'b1;
          state_d         = S_CLASS;
        end
      end
      S_CLASS: begin
        if (stat_i.is_cr) begin
          cmd_o.set_crlf = 1'b1;
          state_d        = stat_i.last_byte ? S_EOL_END : S_STATUS;
        end else if (stat_i.is_ctrlz) begin
          cmd_o.set_stop = 1'b1;
          state_d        = stat_i.line_open ? S_EOL_END : S_STATUS;
        end else if (stat_i.is_eol_char) begin
          state_d = S_EOL_END;
        end else if (stat_i.is_tab) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = stat_i.char_wrap ? S_WRAP_CHAR : S_CHAR;
        end
      end
      S_WRAP_CHAR: begin
        if (stat_i.out_free) begin
          cmd_o.emit = tlsplit_pkg::EMIT_EOL;
          state_d    = S_CHAR;
        end
      end
      S_CHAR: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = tlsplit_pkg::EMIT_CHAR;
          cmd_o.emit_last = !stat_i.last_byte;
          state_d         = stat_i.last_byte ? S_EOL_END : S_IDLE;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_TAB_CHK;
        end
      end
      S_TAB_CHK: begin
        cmd_o.load_cnt = 1'b1;
        state_d        = stat_i.tab_wrap ? S_WRAP_TAB : S_SPACES;
      end
      S_WRAP_TAB: begin
        if (stat_i.out_free) begin
          cmd_o.emit = tlsplit_pkg::EMIT_EOL;
          state_d    = S_SPACES;
        end
      end
      S_SPACES: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = tlsplit_pkg::EMIT_SPACE;
          cmd_o.emit_last = stat_i.cnt_one && !stat_i.last_byte;
          if (stat_i.cnt_one) begin
            state_d = stat_i.last_byte ? S_EOL_END : S_IDLE;
          end
        end
      end
      S_EOL_END: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = tlsplit_pkg::EMIT_EOL;
          cmd_o.emit_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_STATUS: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = tlsplit_pkg::EMIT_STATUS;
          cmd_o.emit_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/text_line_splitter_tab_expand.sv
// ----------------------------------------------------------------------------
// text_line_splitter_tab_expand
// Splits a text byte stream into lines with CR dropping, tab expansion,
// line wrapping and CTRL-Z end of input.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake                payload
//   in       in   in_valid / in_ready      in_data_i   (byte_value, last_byte)
//   out      out  out_valid / out_ready    out_data_o  (one or more per loaded byte)
//   cfg      in   cfg_valid / cfg_ready    cfg_index_i, cfg_data_i
//
// An ordinary byte is accepted, classified and emitted, plus a result for each
// wrap or closing line end. An expanded tab is accepted, classified, run
// through the remainder unit (one bit per cycle over the 10-bit line length,
// then a done check) and a tab stop check, then emits its spaces, after a
// line end if it wraps; no new byte is taken until then. Each result waits
// for a free output register. Reset clears control state, loads the defaults.
// ----------------------------------------------------------------------------
module text_line_splitter_tab_expand (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tlsplit_pkg::in_t                  in_data_i,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tlsplit_pkg::out_t                 out_data_o,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tlsplit_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tlsplit_pkg::CfgDataW-1:0]  cfg_data_i
);

  tlsplit_pkg::cmd_t  cmd;
  tlsplit_pkg::stat_t stat;

  // Config writes are always accepted
  assign cfg_ready = 1'b1;

  // Sequence each accepted byte
  tlsplit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold config, line state and the output register
  tlsplit_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

`ifndef NO_ASSERTIONS
  // A result carries either a character or a line end, never both
  a_char_xor_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(out_data_o.char_valid && out_data_o.end_of_line))
    else $error("result has both char_valid and end_of_line");

  // Length field is zero unless the result closes a line
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_data_o.end_of_line) |-> (out_data_o.line_length == '0))
    else $error("line_length set without end_of_line");

  // CR flag is sticky across results
  a_crlf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && out_data_o.crlf_seen)
      |=> (!out_valid || out_data_o.crlf_seen))
    else $error("crlf_seen dropped");

  // Stop flag is sticky across results
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && out_data_o.input_stopped)
      |=> (!out_valid || out_data_o.input_stopped))
    else $error("input_stopped dropped");
`endif

endmodule

FILE: tb/tlsplit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlsplit_checker
// Watches the byte, result and register channels of the line splitter,
// predicts the line events of every accepted byte and compares each
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module tlsplit_checker
  import tlsplit_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_t                 in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_t                out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         err_cnt_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o
);

  // Register copies
  logic [MaxLineW-1:0] max_line_q;
  logic [TabW-1:0]     tab_width_q;
  logic                keep_tabs_q;
  logic                ignore_ctrlz_q;

  // Line state
  int unsigned line_len;
  logic        crlf_flag;
  logic        stopped;
  logic        line_open;

  out_t        line_q[$];   // predicted line events, oldest first
  out_t        run_q[$];    // events of the byte being split
  out_t        want_ev;
  int unsigned err_cnt = 0;
  int unsigned checked = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic push_event(input logic [CharW-1:0] ch, input logic is_char,
                            input logic is_eol);
    out_t ev;
    ev               = '0;
    ev.out_char      = is_char ? ch : CharNul;
    ev.char_valid    = is_char;
    ev.end_of_line   = is_eol;
    ev.line_length   = is_eol ? LineLenW'(line_len) : '0;
    ev.crlf_seen     = crlf_flag;
    ev.input_stopped = stopped;
    run_q.push_back(ev);
  endtask

  task automatic end_line();
    push_event(CharNul, 1'b0, 1'b1);
    line_len  = 0;
    line_open = 1'b0;
  endtask

  // Split one byte into its line events and queue them.
  task automatic split_byte(input in_t req);
    int unsigned lim;
    int unsigned tw;
    int unsigned gap;
    out_t        tail_ev;
    if (stopped) return;
    run_q.delete();
    // characters a line may hold, from the saturated buffer size
    if (max_line_q < 3) lim = 2;
    else if (max_line_q > 1024) lim = 1023;
    else lim = max_line_q - 1;

    if (req.byte_value == CharCr) begin
      crlf_flag = 1'b1;
      line_open = 1'b1;
    end else if (req.byte_value == CharCtrlZ && !ignore_ctrlz_q) begin
      stopped = 1'b1;
      if (line_open) end_line();
    end else if (req.byte_value == CharLf || req.byte_value == CharNul) begin
      end_line();
    end else if (req.byte_value == CharTab && !keep_tabs_q) begin
      if (tab_width_q == 0) tw = 1;
      else if (tab_width_q > 62) tw = 62;
      else tw = tab_width_q;
      if (tw > lim - 1) tw = lim - 1;
      gap = tw - (line_len % tw);
      if (line_len + gap >= lim) begin
        end_line();
        gap = tw;
      end
      repeat (gap) push_event(CharSpace, 1'b1, 1'b0);
      line_len += gap;
      line_open = 1'b1;
    end else begin
      if (line_len >= lim) end_line();
      push_event(req.byte_value, 1'b1, 1'b0);
      line_len++;
      line_open = 1'b1;
    end

    if (req.last_byte && line_open && !stopped) end_line();
    if (run_q.size() == 0) push_event(CharNul, 1'b0, 1'b0);
    tail_ev = run_q.pop_back();
    tail_ev.last_of_run = 1'b1;
    run_q.push_back(tail_ev);
    foreach (run_q[i]) line_q.push_back(run_q[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q     = MaxLineRst;
      tab_width_q    = TabRst;
      keep_tabs_q    = 1'b0;
      ignore_ctrlz_q = 1'b0;
      line_len       = 0;
      crlf_flag      = 1'b0;
      stopped        = 1'b0;
      line_open      = 1'b0;
      line_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (line_q.size() == 0) begin
          report_mismatch("unpredicted result", out_data_i, 0);
        end else begin
          want_ev = line_q.pop_front();
          if (out_data_i.out_char !== want_ev.out_char)
            report_mismatch("out_char", out_data_i.out_char, want_ev.out_char);
          if (out_data_i.char_valid !== want_ev.char_valid)
            report_mismatch("char_valid", out_data_i.char_valid, want_ev.char_valid);
          if (out_data_i.end_of_line !== want_ev.end_of_line)
            report_mismatch("end_of_line", out_data_i.end_of_line, want_ev.end_of_line);
          if (out_data_i.line_length !== want_ev.line_length)
            report_mismatch("line_length", out_data_i.line_length, want_ev.line_length);
          if (out_data_i.crlf_seen !== want_ev.crlf_seen)
            report_mismatch("crlf_seen", out_data_i.crlf_seen, want_ev.crlf_seen);
          if (out_data_i.input_stopped !== want_ev.input_stopped)
            report_mismatch("input_stopped", out_data_i.input_stopped,
                            want_ev.input_stopped);
          if (out_data_i.last_of_run !== want_ev.last_of_run)
            report_mismatch("last_of_run", out_data_i.last_of_run, want_ev.last_of_run);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MAX_LINE:     max_line_q     = cfg_data_i[MaxLineW-1:0];
          CFG_TAB_WIDTH:    tab_width_q    = cfg_data_i[TabW-1:0];
          CFG_KEEP_TABS:    keep_tabs_q    = cfg_data_i[0];
          CFG_IGNORE_CTRLZ: ignore_ctrlz_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) split_byte(in_data_i);
    end
    err_cnt_o = err_cnt;
    pending_o = line_q.size();
    checked_o = checked;
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives byte and register requests into the line splitter under several
// register settings, stalls the result side at random, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
  import tlsplit_pkg::*;

  // Longest quiet stretch of a correct run is a tab plus a drawn result
  // stall; allow far more before calling it a hang.
  localparam int unsigned IdleLimit  = 2000;
  // Cycles to keep watching once nothing is predicted any more.
  localparam int unsigned TailCycles = 40;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  int unsigned err_cnt;
  int unsigned pending;
  int unsigned checked;
  int unsigned req_cnt     = 0;
  int unsigned setting_cnt = 0;
  int unsigned rx_cnt      = 0;
  int unsigned idle_cycles = 0;
  bit          tx_calm     = 1'b0;   // sender runs without gaps
  bit          rx_calm     = 1'b0;   // receiver runs without stalls

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  text_line_splitter_tab_expand i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data_i   (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data_o  (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  tlsplit_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // Send one byte request. Valid stays high between back-to-back requests;
  // drop it only for a drawn gap, so valid gets one assignment per step.
  task automatic send_byte(input logic [CharW-1:0] b, input logic last);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data  <= '{byte_value: b, last_byte: last};
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    req_cnt++;
    // switch between gapped and gap-free stretches now and then
    if (req_cnt % 25 == 0) tx_calm = ($urandom_range(0, 3) == 0);
  endtask

  // Drop the byte request and wait until every predicted result has come.
  // Sample the count at the falling edge, clear of the checker's update.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  // Write all four registers once the block has gone idle.
  task automatic apply_setting(input logic [CfgDataW-1:0] max_line,
                               input logic [CfgDataW-1:0] tab_width,
                               input logic keep_tabs, input logic ignore_ctrlz);
    settle();
    write_reg(CFG_MAX_LINE, max_line);
    write_reg(CFG_TAB_WIDTH, tab_width);
    write_reg(CFG_KEEP_TABS, CfgDataW'(keep_tabs));
    write_reg(CFG_IGNORE_CTRLZ, CfgDataW'(ignore_ctrlz));
    cfg_valid <= 1'b0;
    setting_cnt++;
  endtask

  // Draw a byte: mostly printable text with line ends, tabs and CRs mixed
  // in, plus raw bytes. Tab-heavy streams push lines toward the wrap point.
  // Never draw CTRL-Z while it ends input, or the run would stop early.
  function automatic logic [CharW-1:0] draw_byte(input bit ignore_ctrlz,
                                                 input bit tab_heavy);
    int unsigned      roll;
    logic [CharW-1:0] b;
    roll = $urandom_range(0, 99);
    if (tab_heavy) begin
      if (roll < 55) b = CharTab;
      else if (roll < 58) b = CharLf;
      else b = CharW'($urandom_range(33, 126));
    end else if (roll < 45) b = CharW'($urandom_range(32, 126));
    else if (roll < 57) b = CharTab;
    else if (roll < 66) b = CharLf;
    else if (roll < 72) b = CharCr;
    else if (roll < 75) b = CharNul;
    else if (roll < 80) b = CharCtrlZ;
    else b = CharW'($urandom_range(0, 255));
    if (!ignore_ctrlz && b == CharCtrlZ) b = CharSpace + CharW'($urandom_range(1, 94));
    return b;
  endfunction

  task automatic run_random(input logic [CfgDataW-1:0] max_line,
                            input logic [CfgDataW-1:0] tab_width,
                            input logic keep_tabs, input logic ignore_ctrlz,
                            input int unsigned n, input bit tab_heavy);
    apply_setting(max_line, tab_width, keep_tabs, ignore_ctrlz);
    repeat (n) send_byte(draw_byte(ignore_ctrlz, tab_heavy), ($urandom_range(0, 19) == 0));
  endtask

  // Result side: draw a stall per result, then hold ready until it moves.
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      rx_cnt++;
      if (rx_cnt % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog: end the run when no request moves on any channel for too long.
  initial begin
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Watchdog: no request moved for %0d cycles", IdleLimit);
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default sizes: plain char, CR flag, tab stop, LF and NUL ends (the last
    // two on empty lines), high byte closing on last, CR-only line
    // closing on last, and a tab as the last byte.
    apply_setting(512, 8, 1'b0, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(CharCr, 1'b0);
    send_byte(CharTab, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(CharLf, 1'b0);
    send_byte(CharNul, 1'b0);
    send_byte(CharLf, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(CharCr, 1'b1);
    send_byte(CharTab, 1'b1);

    // Smallest buffer: the third char wraps, each tab wraps, tab width
    // clamps to the buffer, and CTRL-Z passes as an ordinary byte.
    apply_setting(3, 62, 1'b0, 1'b1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0);
    send_byte(CharTab, 1'b0);
    send_byte(CharTab, 1'b0);
    send_byte(CharCtrlZ, 1'b0);
    send_byte(CharLf, 1'b0);

    // All-ones sizes saturate to the top of range; tabs pass through.
    apply_setting(11'h7FF, 63, 1'b1, 1'b1);
    send_byte(CharTab, 1'b0);
    send_byte(CharTab, 1'b1);

    // Zero sizes saturate to the bottom of range.
    apply_setting(0, 0, 1'b0, 1'b0);
    send_byte(CharTab, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h78, 1'b1);

    // Random streams across fixed extremes and drawn settings.
    run_random(40, 8, 1'b0, 1'b1, 44, 1'b0);
    run_random(1024, 62, 1'b0, 1'b1, 44, 1'b1);
    run_random(3, 1, 1'b1, 1'b0, 44, 1'b0);
    run_random(11'h7FF, 0, 1'b0, 1'b0, 44, 1'b0);
    repeat (3) begin
      run_random(CfgDataW'($urandom_range(3, 30)), CfgDataW'($urandom_range(0, 63)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 44, 1'b0);
    end
    run_random(CfgDataW'($urandom_range(0, 2047)), CfgDataW'($urandom_range(0, 63)),
               1'b0, 1'($urandom_range(0, 1)), 44, 1'b1);

    // CTRL-Z ends input, with or without an open line; later bytes are
    // dropped without results.
    apply_setting(12, 4, 1'b0, 1'b0);
    if ($urandom_range(0, 1) == 1) send_byte(8'h71, 1'b0);
    send_byte(CharCtrlZ, 1'($urandom_range(0, 1)));
    repeat (3) send_byte(CharW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    // Hold for stray results after the last prediction has been met.
    settle();
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d byte requests under %0d register settings, checked %0d results.",
             req_cnt, setting_cnt, checked);
    $display("Run covered wraps, tab stops, CR flag, LF/NUL line ends and the CTRL-Z stop.");
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
